>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file eps_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define EPS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, off while reset is low.
`define EPS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

// Check in the cycle after reset is seen low.
`define EPS_ASSERT_RESET(lbl, clk, rst_n, post, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (post)) else $error(msg);

`endif

>>> rtl/core/eps_pkg.sv
// Shared widths, constants, register codes and stage payload types.
// No dependencies; used by every module of the speed drive block.
package eps_pkg;

  localparam int WINDOW_LEN_DEF = 5;
  localparam int WINDOW_LEN_MAX = 16;

  localparam int RAW_W    = 16;
  localparam int PULSE_W  = RAW_W + 1;
  localparam int SUM_W    = PULSE_W + $clog2(WINDOW_LEN_MAX);
  localparam int MAG_W    = SUM_W - 1;
  localparam int NUM_W    = MAG_W + 8;
  localparam int RECIP_W  = NUM_W + 1;
  localparam int SPEED_W  = 20;
  localparam int QUOT_W   = SPEED_W - 1;
  localparam int TARGET_W = 14;
  localparam int GAIN_W   = 16;
  localparam int GAIN100_W = GAIN_W + 7;
  localparam int DATA_W   = 16;
  localparam int DELTA_W  = SPEED_W + 1;
  localparam int PROD_W   = DELTA_W + GAIN100_W;
  localparam int CFG_IDX_W = 3;

  localparam int COUNTS_PER_REV  = 5200;
  localparam int SPEED_SCALE_NUM = 64000;
  localparam int SCALE_GCD       = 400;
  localparam int SPEED_MUL       = SPEED_SCALE_NUM / SCALE_GCD;
  localparam int SPEED_DIV       = COUNTS_PER_REV / SCALE_GCD;
  localparam int DRIVE_GAIN      = 100;
  localparam int PULSE_MAX       = 32768;
  localparam int SPEED_LIMIT     = (PULSE_MAX * SPEED_MUL + SPEED_DIV / 2) / SPEED_DIV;

  localparam int TARGET_RST = 179;
  localparam int GAIN_RST   = 256;
  localparam int DMIN_RST   = 500;
  localparam int DMAX_RST   = 5000;
  localparam int PERIOD_RST = 40000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SPEED = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_DRIVE_MIN    = 3'd2,
    CFG_DRIVE_MAX    = 3'd3,
    CFG_PWM_PERIOD   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TARGET_W-1:0]  target_speed;
    logic signed [GAIN100_W-1:0] gain100;
    logic [DATA_W-1:0]           drive_min;
    logic [DATA_W-1:0]           drive_max;
    logic [DATA_W-1:0]           pwm_period;
  } cfg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    on;
  } s1_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic                      on;
  } s2_t;

endpackage

>>> rtl/core/eps_regs.sv
// Configuration register bank with index decode and width truncation.
// Depends on eps_pkg.
module eps_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eps_pkg::DATA_W-1:0]     cfg_wdata,
  output eps_pkg::cfg_t                  cfg
);

  eps_pkg::cfg_t cfg_r;
  logic signed [eps_pkg::GAIN100_W-1:0] gain100_nxt;

  assign gain100_nxt = eps_pkg::GAIN100_W'($signed(cfg_wdata))
                     * eps_pkg::GAIN100_W'(eps_pkg::DRIVE_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed <= eps_pkg::TARGET_W'(eps_pkg::TARGET_RST);
      cfg_r.gain100      <= eps_pkg::GAIN100_W'(eps_pkg::GAIN_RST * eps_pkg::DRIVE_GAIN);
      cfg_r.drive_min    <= eps_pkg::DATA_W'(eps_pkg::DMIN_RST);
      cfg_r.drive_max    <= eps_pkg::DATA_W'(eps_pkg::DMAX_RST);
      cfg_r.pwm_period   <= eps_pkg::DATA_W'(eps_pkg::PERIOD_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        eps_pkg::CFG_TARGET_SPEED: cfg_r.target_speed <= cfg_wdata[eps_pkg::TARGET_W-1:0];
        eps_pkg::CFG_PROP_GAIN:    cfg_r.gain100      <= gain100_nxt;
        eps_pkg::CFG_DRIVE_MIN:    cfg_r.drive_min    <= cfg_wdata;
        eps_pkg::CFG_DRIVE_MAX:    cfg_r.drive_max    <= cfg_wdata;
        eps_pkg::CFG_PWM_PERIOD:   cfg_r.pwm_period   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/eps_window.sv
// Input stage: negate the encoder count, update the pulse ring and running sum.
// Depends on eps_pkg.
module eps_window #(
  parameter int WINDOW_LEN = eps_pkg::WINDOW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [eps_pkg::RAW_W-1:0]  in_encoder_raw,
  input  logic                       in_motor_enable,
  input  logic                       in_load_request,
  input  logic [1:0]                 in_remote_switch,
  output logic                       s1_valid,
  input  logic                       s1_ready,
  output eps_pkg::s1_t               s1_data
);

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LEN - 1);

  logic signed [eps_pkg::PULSE_W-1:0] win_r [WINDOW_LEN];
  logic [IDX_W-1:0]                   idx_r;
  logic signed [eps_pkg::SUM_W-1:0]   sum_r;
  logic signed [eps_pkg::SUM_W-1:0]   sum_nxt;
  logic signed [eps_pkg::PULSE_W-1:0] pulse;
  logic                               valid_r;
  eps_pkg::s1_t                       data_r;
  logic                               accept;

  assign in_ready = !valid_r || s1_ready;
  assign accept   = in_valid && in_ready;

  assign pulse   = -$signed({in_encoder_raw[eps_pkg::RAW_W-1], in_encoder_raw});
  assign sum_nxt = sum_r + eps_pkg::SUM_W'(pulse) - eps_pkg::SUM_W'(win_r[idx_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_LEN; k++) begin
        win_r[k] <= '0;
      end
      idx_r   <= '0;
      sum_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        win_r[idx_r] <= pulse;
        idx_r        <= (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
        sum_r        <= sum_nxt;
      end
      if (in_ready) begin
        valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r.sum <= sum_nxt;
      data_r.on  <= in_motor_enable && in_load_request && (in_remote_switch == 2'd1);
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

>>> rtl/core/eps_speed.sv
// Speed stage: scale the window sum to Q12.8 rev/s with rounding half away from zero.
// Depends on eps_pkg; divides by a constant through a reciprocal multiply.
module eps_speed #(
  parameter int WINDOW_LEN = eps_pkg::WINDOW_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s1_valid,
  output logic          s1_ready,
  input  eps_pkg::s1_t  s1_data,
  output logic          s2_valid,
  input  logic          s2_ready,
  output eps_pkg::s2_t  s2_data
);

  localparam int DIV   = eps_pkg::SPEED_DIV * WINDOW_LEN;
  localparam int HALF  = DIV / 2;
  localparam int SHIFT = eps_pkg::NUM_W + $clog2(DIV);
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(DIV - 1)) / 64'(DIV);
  localparam logic [eps_pkg::RECIP_W-1:0] RECIP = eps_pkg::RECIP_W'(RECIP64);
  localparam int QP_W = eps_pkg::NUM_W + eps_pkg::RECIP_W;

  logic                              neg;
  logic signed [eps_pkg::SUM_W-1:0]  abs_sum;
  logic [eps_pkg::MAG_W-1:0]         mag;
  logic [eps_pkg::NUM_W-1:0]         num;
  logic [QP_W-1:0]                   qprod;
  logic [eps_pkg::QUOT_W-1:0]        quot;
  logic signed [eps_pkg::SPEED_W-1:0] speed;
  logic                              valid_r;
  eps_pkg::s2_t                      data_r;

  assign s1_ready = !valid_r || s2_ready;

  assign neg     = s1_data.sum[eps_pkg::SUM_W-1];
  assign abs_sum = neg ? -$signed(s1_data.sum) : $signed(s1_data.sum);
  assign mag     = abs_sum[eps_pkg::MAG_W-1:0];
  assign num     = eps_pkg::NUM_W'(mag) * eps_pkg::NUM_W'(eps_pkg::SPEED_MUL)
                 + eps_pkg::NUM_W'(HALF);
  assign qprod   = QP_W'(num) * QP_W'(RECIP);
  assign quot    = qprod[SHIFT +: eps_pkg::QUOT_W];
  assign speed   = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      data_r.speed <= speed;
      data_r.on    <= s1_data.on;
    end
  end

  assign s2_valid = valid_r;
  assign s2_data  = data_r;

endmodule

>>> rtl/core/eps_drive.sv
// Drive stages: gain multiply, then clamp and PWM compare into the result register.
// Depends on eps_pkg and the register bank output.
module eps_drive (
  input  logic                               clk,
  input  logic                               rst_n,
  input  eps_pkg::cfg_t                      cfg,
  input  logic                               s2_valid,
  output logic                               s2_ready,
  input  eps_pkg::s2_t                       s2_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [eps_pkg::DATA_W-1:0]         out_compare_value,
  output logic [eps_pkg::DATA_W-1:0]         out_drive_value,
  output logic signed [eps_pkg::SPEED_W-1:0] out_avg_speed
);

  localparam int DW = eps_pkg::DATA_W;
  localparam int PW = eps_pkg::PROD_W;

  logic signed [eps_pkg::DELTA_W-1:0]  delta;
  logic signed [PW-1:0]                prod_nxt;
  logic signed [PW-1:0]                prod_r;
  logic signed [eps_pkg::SPEED_W-1:0]  speed_r;
  logic                                on_r;
  logic                                mul_valid_r;
  logic                                mul_ready;

  logic signed [PW-1:0]                lo;
  logic signed [PW-1:0]                hi;
  logic signed [PW-1:0]                p_lo;
  logic signed [PW-1:0]                p_hi;
  logic [DW-1:0]                       drive;
  logic [DW-1:0]                       cmp;

  logic                                out_valid_r;
  logic [DW-1:0]                       cmp_r;
  logic [DW-1:0]                       drive_r;
  logic signed [eps_pkg::SPEED_W-1:0]  avg_r;

  assign mul_ready = !out_valid_r || out_ready;
  assign s2_ready  = !mul_valid_r || mul_ready;

  assign delta    = eps_pkg::DELTA_W'($signed(cfg.target_speed))
                  - eps_pkg::DELTA_W'($signed(s2_data.speed));
  assign prod_nxt = delta * $signed(cfg.gain100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (s2_ready) begin
      mul_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      prod_r  <= prod_nxt;
      speed_r <= s2_data.speed;
      on_r    <= s2_data.on;
    end
  end

  assign lo    = PW'({1'b0, cfg.drive_min, {DW{1'b0}}});
  assign hi    = PW'({1'b0, cfg.drive_max, {DW{1'b0}}});
  assign p_lo  = (prod_r < lo) ? lo : prod_r;
  assign p_hi  = (p_lo > hi) ? hi : p_lo;
  assign drive = p_hi[2*DW-1:DW];

  always_comb begin
    if (!on_r) begin
      cmp = cfg.pwm_period;
    end else if (drive > cfg.pwm_period) begin
      cmp = '0;
    end else begin
      cmp = cfg.pwm_period - drive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mul_ready) begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_valid_r && mul_ready) begin
      cmp_r   <= cmp;
      drive_r <= drive;
      avg_r   <= speed_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_compare_value = cmp_r;
  assign out_drive_value   = drive_r;
  assign out_avg_speed     = avg_r;

endmodule

>>> rtl/core/encoder_speed_p_drive.sv
// Encoder speed proportional drive: accepts one request per cycle unless out_ready stalls
// the pipe, which has four pipeline registers (ring and running sum, reciprocal multiply,
// gain multiply, clamp and compare).
// Synchronous active-low reset clears the pulse ring, running sum and stage valids
// and loads the register defaults.
// Depends on eps_pkg, eps_regs, eps_window, eps_speed and eps_drive.
module encoder_speed_p_drive #(
  parameter int WINDOW_LEN = eps_pkg::WINDOW_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eps_pkg::DATA_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [eps_pkg::RAW_W-1:0]          in_encoder_raw,
  input  logic                               in_motor_enable,
  input  logic                               in_load_request,
  input  logic [1:0]                         in_remote_switch,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [eps_pkg::DATA_W-1:0]         out_compare_value,
  output logic [eps_pkg::DATA_W-1:0]         out_drive_value,
  output logic signed [eps_pkg::SPEED_W-1:0] out_avg_speed
);

  eps_pkg::cfg_t cfg;
  eps_pkg::s1_t  s1_data;
  eps_pkg::s2_t  s2_data;
  logic          s1_valid;
  logic          s1_ready;
  logic          s2_valid;
  logic          s2_ready;

  eps_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  eps_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_encoder_raw   (in_encoder_raw),
    .in_motor_enable  (in_motor_enable),
    .in_load_request  (in_load_request),
    .in_remote_switch (in_remote_switch),
    .s1_valid         (s1_valid),
    .s1_ready         (s1_ready),
    .s1_data          (s1_data)
  );

  eps_speed #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_speed (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_data),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2_data  (s2_data)
  );

  eps_drive u_drive (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .s2_valid          (s2_valid),
    .s2_ready          (s2_ready),
    .s2_data           (s2_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_compare_value (out_compare_value),
    .out_drive_value   (out_drive_value),
    .out_avg_speed     (out_avg_speed)
  );

endmodule

>>> rtl/core/eps_checker.sv
// Port-level checker for the speed drive block, bound to the top level.
// Depends on eps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module eps_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [eps_pkg::SPEED_W-1:0] out_avg_speed
);

  localparam logic signed [eps_pkg::SPEED_W-1:0] SPD_HI =
    eps_pkg::SPEED_W'(eps_pkg::SPEED_LIMIT);
  localparam logic signed [eps_pkg::SPEED_W-1:0] SPD_LO = -SPD_HI;

  logic speed_ok;
  logic out_stall;

  assign speed_ok  = (out_avg_speed <= SPD_HI) && (out_avg_speed >= SPD_LO);
  assign out_stall = out_valid && !out_ready;

  `EPS_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_valid, "result valid right after reset")
  `EPS_ASSERT_IMPL(a_empty_ready, clk, rst_n, !out_valid, in_ready, "empty pipe refused request")
  `EPS_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_stall, out_valid, "stalled result dropped")
  `EPS_ASSERT_IMPL(a_speed_range, clk, rst_n, out_valid, speed_ok, "average speed out of range")

endmodule

bind encoder_speed_p_drive eps_checker u_eps_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for encoder_speed_p_drive: directed table, then random ticks
// over several register settings, checked against an in-bench speed and drive predictor.
// Depends on eps_pkg and the encoder_speed_p_drive RTL.
module testbench;

  localparam int PIPE_LATENCY = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 9;
  localparam int HOLD_CYCLES  = 80;
  localparam int DIR_N        = 22;
  localparam logic [1:0] SWITCH_DRIVE = 2'd1;
  localparam logic [eps_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

  typedef struct packed {
    logic [eps_pkg::DATA_W-1:0]         compare_value;
    logic [eps_pkg::DATA_W-1:0]         drive_value;
    logic signed [eps_pkg::SPEED_W-1:0] avg_speed;
  } drive_result_t;

  typedef struct packed {
    logic [eps_pkg::RAW_W-1:0] raw;
    logic                      enable;
    logic                      load;
    logic [1:0]                switch_pos;
    logic                      fixed;
    drive_result_t             res;
  } tick_row_t;

  typedef struct packed {
    logic [eps_pkg::DATA_W-1:0] target;
    logic [eps_pkg::DATA_W-1:0] gain;
    logic [eps_pkg::DATA_W-1:0] dmin;
    logic [eps_pkg::DATA_W-1:0] dmax;
    logic [eps_pkg::DATA_W-1:0] period;
  } reg_set_t;

  localparam drive_result_t NO_RESULT = '0;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 cfg_we;
  logic [eps_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [eps_pkg::DATA_W-1:0]           cfg_wdata;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [eps_pkg::RAW_W-1:0]            in_encoder_raw;
  logic                                 in_motor_enable;
  logic                                 in_load_request;
  logic [1:0]                           in_remote_switch;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [eps_pkg::DATA_W-1:0]           out_compare_value;
  logic [eps_pkg::DATA_W-1:0]           out_drive_value;
  logic signed [eps_pkg::SPEED_W-1:0]   out_avg_speed;

  logic                                 row_fixed;
  drive_result_t                        row_result;
  bit                                   steady;
  bit                                   hold_req;

  logic signed [eps_pkg::TARGET_W-1:0]  set_target;
  logic signed [eps_pkg::GAIN_W-1:0]    set_gain;
  logic [eps_pkg::DATA_W-1:0]           set_dmin;
  logic [eps_pkg::DATA_W-1:0]           set_dmax;
  logic [eps_pkg::DATA_W-1:0]           set_period;
  logic signed [eps_pkg::PULSE_W-1:0]   pulse_ring [eps_pkg::WINDOW_LEN_DEF];
  int                                   ring_pos;

  drive_result_t                        pending_results [$];
  int                                   errors;
  int                                   requests_sent;
  int                                   results_seen;
  int                                   settings_run;
  int                                   cycle_count;

  encoder_speed_p_drive u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_encoder_raw    (in_encoder_raw),
    .in_motor_enable   (in_motor_enable),
    .in_load_request   (in_load_request),
    .in_remote_switch  (in_remote_switch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_compare_value (out_compare_value),
    .out_drive_value   (out_drive_value),
    .out_avg_speed     (out_avg_speed)
  );

  always #5 clk = ~clk;

  tick_row_t dir_rows [DIR_N] = '{
    '{16'h0000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b1, '{16'd39500, 16'd500, 20'sd0}},
    '{16'h0000, 1'b0, 1'b1, SWITCH_DRIVE, 1'b1, '{16'd40000, 16'd500, 20'sd0}},
    '{16'h0000, 1'b1, 1'b0, SWITCH_DRIVE, 1'b1, '{16'd40000, 16'd500, 20'sd0}},
    '{16'h0000, 1'b1, 1'b1, 2'd0,         1'b1, '{16'd40000, 16'd500, 20'sd0}},
    '{16'h0000, 1'b1, 1'b1, 2'd2,         1'b1, '{16'd40000, 16'd500, 20'sd0}},
    '{16'h0000, 1'b1, 1'b1, 2'd3,         1'b1, '{16'd40000, 16'd500, 20'sd0}},
    '{16'h8000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h8000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h8000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h8000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h8000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h7fff, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h7fff, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h7fff, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h7fff, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h7fff, 1'b0, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'hffff, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h0001, 1'b1, 1'b0, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h5555, 1'b1, 1'b1, 2'd3,         1'b0, NO_RESULT},
    '{16'haaaa, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h0000, 1'b1, 1'b1, SWITCH_DRIVE, 1'b0, NO_RESULT},
    '{16'h0000, 1'b1, 1'b1, 2'd2,         1'b0, NO_RESULT}
  };

  reg_set_t limit_sets [5] = '{
    '{16'h1fff, 16'h7fff, 16'd0,    16'd65535, 16'd65535},
    '{16'h2000, 16'h8000, 16'd0,    16'd65535, 16'd0},
    '{16'hc0b3, 16'd256,  16'd3000, 16'd1000,  16'd2000},
    '{16'h0000, 16'h0010, 16'd0,    16'd65535, 16'd40000},
    '{16'd179,  16'd256,  16'd500,  16'd5000,  16'd40000}
  };

  function automatic void reset_model();
    set_target = eps_pkg::TARGET_W'(eps_pkg::TARGET_RST);
    set_gain   = eps_pkg::GAIN_W'(eps_pkg::GAIN_RST);
    set_dmin   = eps_pkg::DATA_W'(eps_pkg::DMIN_RST);
    set_dmax   = eps_pkg::DATA_W'(eps_pkg::DMAX_RST);
    set_period = eps_pkg::DATA_W'(eps_pkg::PERIOD_RST);
    foreach (pulse_ring[k]) pulse_ring[k] = '0;
    ring_pos = 0;
  endfunction

  function automatic void write_model(input logic [eps_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [eps_pkg::DATA_W-1:0] data);
    case (idx)
      eps_pkg::CFG_TARGET_SPEED: set_target = data[eps_pkg::TARGET_W-1:0];
      eps_pkg::CFG_PROP_GAIN:    set_gain   = data;
      eps_pkg::CFG_DRIVE_MIN:    set_dmin   = data;
      eps_pkg::CFG_DRIVE_MAX:    set_dmax   = data;
      eps_pkg::CFG_PWM_PERIOD:   set_period = data;
      default: ;
    endcase
  endfunction

  function automatic drive_result_t predict_drive(input logic [eps_pkg::RAW_W-1:0] raw,
                                                  input logic enable, load,
                                                  input logic [1:0] switch_pos);
    longint sum, num, mag, quo, den, speed, delta, prod, lo, hi;
    drive_result_t r;
    pulse_ring[ring_pos] = eps_pkg::PULSE_W'(-longint'($signed(raw)));
    ring_pos = (ring_pos + 1) % eps_pkg::WINDOW_LEN_DEF;
    sum = 0;
    foreach (pulse_ring[k]) sum += longint'(pulse_ring[k]);
    num = sum * eps_pkg::SPEED_SCALE_NUM;
    den = longint'(eps_pkg::COUNTS_PER_REV) * eps_pkg::WINDOW_LEN_DEF;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    speed = (num < 0) ? -quo : quo;
    if (speed > 524287) speed = 524287;
    if (speed < -524288) speed = -524288;
    delta = longint'(set_target) - speed;
    prod = delta * eps_pkg::DRIVE_GAIN * longint'(set_gain);
    lo = longint'(set_dmin) * 65536;
    hi = longint'(set_dmax) * 65536;
    if (prod < lo) prod = lo;
    if (prod > hi) prod = hi;
    r.drive_value = eps_pkg::DATA_W'(prod >>> 16);
    r.avg_speed = eps_pkg::SPEED_W'(speed);
    if (enable && load && switch_pos == SWITCH_DRIVE) begin
      r.compare_value = (r.drive_value > set_period) ? '0 : set_period - r.drive_value;
    end else begin
      r.compare_value = set_period;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) write_model(cfg_index, cfg_wdata);
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          errors++;
          $error("result with no request outstanding: compare %0d drive %0d speed %0d",
                 out_compare_value, out_drive_value, out_avg_speed);
        end else begin
          want = pending_results.pop_front();
          check_field("compare_value", want.compare_value, out_compare_value);
          check_field("drive_value", want.drive_value, out_drive_value);
          check_field("avg_speed", want.avg_speed, out_avg_speed);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_drive(in_encoder_raw, in_motor_enable, in_load_request,
                             in_remote_switch);
        if (row_fixed) want = row_result;
        pending_results.push_back(want);
        requests_sent++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int next_gap();
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return idle_len();
  endfunction

  function automatic tick_row_t random_tick();
    tick_row_t t;
    int r;
    t = '0;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      t.raw = eps_pkg::RAW_W'(int'($urandom_range(0, 400)) - 200);
    end else if (r < 85) begin
      t.raw = eps_pkg::RAW_W'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: t.raw = 16'h8000;
        1: t.raw = 16'h7fff;
        2: t.raw = 16'hffff;
        3: t.raw = 16'h0001;
        default: t.raw = 16'h0000;
      endcase
    end
    if ($urandom_range(0, 3) != 0) begin
      t.enable = 1'b1;
      t.load = 1'b1;
      t.switch_pos = SWITCH_DRIVE;
    end else begin
      t.enable = 1'($urandom);
      t.load = 1'($urandom);
      t.switch_pos = 2'($urandom);
    end
    return t;
  endfunction

  task automatic send_tick(input tick_row_t row, input int gap);
    @(negedge clk);
    in_encoder_raw   <= row.raw;
    in_motor_enable  <= row.enable;
    in_load_request  <= row.load;
    in_remote_switch <= row.switch_pos;
    row_fixed        <= row.fixed;
    row_result       <= row.res;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [eps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [eps_pkg::DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sink: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 25) stall_left = idle_len();
      end
    end
  end

  initial begin
    reg_set_t s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_encoder_raw = '0;
    in_motor_enable = 1'b0;
    in_load_request = 1'b0;
    in_remote_switch = '0;
    row_fixed = 1'b0;
    row_result = NO_RESULT;
    steady = 1'b0;
    hold_req = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_tick(dir_rows[i], next_gap());

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 5) begin
        s = limit_sets[p];
      end else begin
        s.target = eps_pkg::DATA_W'($urandom);
        s.gain   = $urandom_range(0, 1) ? eps_pkg::DATA_W'($urandom)
                                        : eps_pkg::DATA_W'($urandom_range(0, 64));
        s.dmin   = eps_pkg::DATA_W'($urandom);
        s.dmax   = eps_pkg::DATA_W'($urandom);
        s.period = eps_pkg::DATA_W'($urandom);
      end
      write_reg(eps_pkg::CFG_TARGET_SPEED, s.target);
      write_reg(eps_pkg::CFG_PROP_GAIN, s.gain);
      write_reg(eps_pkg::CFG_DRIVE_MIN, s.dmin);
      write_reg(eps_pkg::CFG_DRIVE_MAX, s.dmax);
      write_reg(eps_pkg::CFG_PWM_PERIOD, s.period);
      write_reg(eps_pkg::CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(0, 2)),
                eps_pkg::DATA_W'($urandom));
      settings_run++;
      steady = (p == 4);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 20) hold_req = 1'b1;
        if (p == 6 && i == 50) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        send_tick(random_tick(), (p == 3 && i >= 20 && i < 60) ? 0 : next_gap());
      end
    end
    steady = 1'b0;
    wait_drained();

    if (pending_results.size() != 0) begin
      errors++;
      $error("%0d results never arrived", pending_results.size());
    end
    $display("Covered %0d requests (%0d from the directed table) and %0d results",
             requests_sent, DIR_N, results_seen);
    $display("across %0d register settings, incl. limit gains, inverted clamps, zero period",
             settings_run + 1);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
